@@ rtl/xrf_pkg.sv @@
`default_nettype none

package xrf_pkg;

   // Length datapath width default
   localparam int LENGTH_BITS_DEFAULT = 27;

   // Configuration port geometry
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 27;
   localparam int SETUP_LIMIT_BITS = 18;
   localparam int BIG_LIMIT_BITS   = 27;

   // Limit values after reset
   localparam logic [SETUP_LIMIT_BITS-1:0] SETUP_LIMIT_RESET = 18'd4096;
   localparam logic [BIG_LIMIT_BITS-1:0]   BIG_LIMIT_RESET   = 27'd104857600;

   // Header sizes in bytes
   localparam int SETUP_HDR = 12;
   localparam int REQ_HDR   = 4;
   localparam int BIG_HDR   = 8;
   localparam int HDR_BYTES = 12;

   // First setup byte that selects big-endian order
   localparam logic [7:0] BIG_ENDIAN_MARK = 8'h42;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SETUP_LIMIT       = 2'd0,
      CSR_BIG_REQUEST_LIMIT = 2'd1
   } csr_index_type;

endpackage

`default_nettype wire

@@ rtl/xrf_req_if.sv @@
`default_nettype none

// Byte stream channel
interface xrf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       burst_last;

   modport source (output valid, output in_byte, output burst_last, input ready);
   modport sink   (input valid, input in_byte, input burst_last, output ready);
endinterface

`default_nettype wire

@@ rtl/xrf_rsp_if.sv @@
`default_nettype none

// Framed byte channel
interface xrf_rsp_if #(
   parameter int LENGTH_BITS = xrf_pkg::LENGTH_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [7:0]             out_byte;
   logic                   first_of_message;
   logic                   last_of_message;
   logic                   setup_message;
   logic                   big_endian;
   logic [LENGTH_BITS-1:0] message_length;
   logic [LENGTH_BITS-1:0] bytes_remaining;
   logic                   length_forced;
   logic                   flushed_setup;

   modport source (
      output valid, output out_byte, output first_of_message, output last_of_message,
      output setup_message, output big_endian, output message_length,
      output bytes_remaining, output length_forced, output flushed_setup,
      input ready
   );
   modport sink (
      input valid, input out_byte, input first_of_message, input last_of_message,
      input setup_message, input big_endian, input message_length,
      input bytes_remaining, input length_forced, input flushed_setup,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/xrf_input_reg.sv @@
`default_nettype none

// Input register: holds one accepted beat until the framer takes it
module xrf_input_reg (
   input  wire logic  clock,
   input  wire logic  reset,
   xrf_req_if.sink    req_bus,
   xrf_req_if.source  item_bus
);

   logic       valid_ff;
   logic [7:0] in_byte_ff;
   logic       burst_last_ff;
   logic       load;

   // free when empty or when the held beat leaves this cycle
   assign req_bus.ready = !valid_ff || item_bus.ready;
   assign load          = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff    <= req_bus.in_byte;
         burst_last_ff <= req_bus.burst_last;
      end
   end

   assign item_bus.valid      = valid_ff;
   assign item_bus.in_byte    = in_byte_ff;
   assign item_bus.burst_last = burst_last_ff;

endmodule

`default_nettype wire

@@ rtl/xrf_frame_core.sv @@
`default_nettype none

// Framing state, header capture, length decode and limits
module xrf_frame_core #(
   parameter int LENGTH_BITS = xrf_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [xrf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [xrf_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   xrf_req_if.sink                                  item_bus,
   xrf_rsp_if.source                                res_bus
);

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX     = '1;
   localparam logic [31:0]            LIMIT_CAP     = 32'((64'd1 << LENGTH_BITS) - 64'd1);
   localparam logic [LENGTH_BITS-1:0] LEN_SETUP_HDR = LENGTH_BITS'(xrf_pkg::SETUP_HDR);
   localparam logic [LENGTH_BITS-1:0] LEN_REQ_HDR   = LENGTH_BITS'(xrf_pkg::REQ_HDR);
   localparam logic [LENGTH_BITS-1:0] LEN_BIG_HDR   = LENGTH_BITS'(xrf_pkg::BIG_HDR);
   localparam logic [LENGTH_BITS-1:0] LEN_HDR_BYTES = LENGTH_BITS'(xrf_pkg::HDR_BYTES);

   // configuration
   logic [xrf_pkg::SETUP_LIMIT_BITS-1:0] setup_limit_ff;
   logic [xrf_pkg::BIG_LIMIT_BITS-1:0]   big_limit_ff;

   // framing state
   logic                   expect_setup_ff, expect_setup_in;
   logic                   order_big_ff, order_big_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [LENGTH_BITS-1:0] target_ff, target_in;
   logic                   known_ff, known_in;
   logic                   flush_ff, flush_in;
   logic                   forced_ff, forced_in;
   logic [7:0]             hdr_ff [xrf_pkg::HDR_BYTES];

   // per-beat decode
   logic                   fire;
   logic [7:0]             cur;
   logic                   first;
   logic [LENGTH_BITS-1:0] count_inc;
   logic [15:0]            auth_a, auth_b;
   logic [16:0]            pad_a, pad_b;
   logic [17:0]            setup_len;
   logic [15:0]            req_field;
   logic [17:0]            req_len;
   logic [31:0]            big_field, big_len, big_cap;
   logic                   big_bad;
   logic [LENGTH_BITS-1:0] target_now;
   logic                   known_now, flush_now, forced_now;
   logic [LENGTH_BITS-1:0] msg_len, remain;
   logic                   done;

   assign fire           = item_bus.valid && res_bus.ready;
   assign item_bus.ready = res_bus.ready;
   assign res_bus.valid  = item_bus.valid;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         setup_limit_ff <= xrf_pkg::SETUP_LIMIT_RESET;
         big_limit_ff   <= xrf_pkg::BIG_LIMIT_RESET;
      end else if (csr_we) begin
         case (xrf_pkg::csr_index_type'(csr_index))
            xrf_pkg::CSR_SETUP_LIMIT: begin
               setup_limit_ff <= csr_wdata[xrf_pkg::SETUP_LIMIT_BITS-1:0];
            end
            xrf_pkg::CSR_BIG_REQUEST_LIMIT: begin
               big_limit_ff <= csr_wdata[xrf_pkg::BIG_LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cur       = item_bus.in_byte;
   assign first     = (count_ff == '0);
   assign order_big_in = (expect_setup_ff && first) ? (cur == xrf_pkg::BIG_ENDIAN_MARK)
                                                    : order_big_ff;
   assign count_inc = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;

   // setup length: 12 plus both auth lengths padded to 4
   assign auth_a    = order_big_in ? {hdr_ff[6], hdr_ff[7]} : {hdr_ff[7], hdr_ff[6]};
   assign auth_b    = order_big_in ? {hdr_ff[8], hdr_ff[9]} : {hdr_ff[9], hdr_ff[8]};
   assign pad_a     = ({1'b0, auth_a} + 17'd3) & 17'h1FFFC;
   assign pad_b     = ({1'b0, auth_b} + 17'd3) & 17'h1FFFC;
   assign setup_len = 18'(xrf_pkg::SETUP_HDR) + {1'b0, pad_a} + {1'b0, pad_b};

   // request length: byte 3 is the beat in hand
   assign req_field = order_big_in ? {hdr_ff[2], cur} : {cur, hdr_ff[2]};
   assign req_len   = {req_field, 2'b00};

   // big request length: byte 7 is the beat in hand, wraps to 32 bits
   assign big_field = order_big_in ? {hdr_ff[4], hdr_ff[5], hdr_ff[6], cur}
                                   : {cur, hdr_ff[6], hdr_ff[5], hdr_ff[4]};
   assign big_len   = {big_field[29:0], 2'b00};
   assign big_cap   = ({5'd0, big_limit_ff} > LIMIT_CAP) ? LIMIT_CAP : {5'd0, big_limit_ff};
   assign big_bad   = (big_len < 32'(xrf_pkg::BIG_HDR)) || (big_len > big_cap);

   // length decode and framing marks
   always_comb begin
      target_now = target_ff;
      known_now  = known_ff;
      flush_now  = flush_ff;
      forced_now = forced_ff;
      if (expect_setup_ff) begin
         if (!known_ff && !flush_ff && count_inc == LEN_SETUP_HDR) begin
            if (setup_len > setup_limit_ff) begin
               flush_now = 1'b1;
            end else begin
               known_now  = 1'b1;
               target_now = LENGTH_BITS'(setup_len);
            end
         end
      end else if (!known_ff) begin
         if (count_inc == LEN_REQ_HDR) begin
            if (req_len != '0) begin
               known_now  = 1'b1;
               target_now = LENGTH_BITS'(req_len);
            end else begin
               target_now = LEN_BIG_HDR;
            end
         end else if (count_inc == LEN_BIG_HDR) begin
            known_now = 1'b1;
            if (big_bad) begin
               forced_now = 1'b1;
               target_now = LEN_BIG_HDR;
            end else begin
               target_now = LENGTH_BITS'(big_len);
            end
         end
      end

      msg_len = '0;
      remain  = '0;
      done    = 1'b0;
      if (flush_now) begin
         msg_len = count_inc;
         done    = item_bus.burst_last;
      end else begin
         remain = (count_inc < target_now) ? target_now - count_inc : '0;
         if (known_now) begin
            msg_len = target_now;
            done    = (remain == '0);
         end
      end

      // message complete: back to a fresh request header
      expect_setup_in = done ? 1'b0 : expect_setup_ff;
      count_in        = done ? '0 : count_inc;
      target_in       = done ? LEN_REQ_HDR : target_now;
      known_in        = done ? 1'b0 : known_now;
      flush_in        = done ? 1'b0 : flush_now;
      forced_in       = done ? 1'b0 : forced_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_setup_ff <= 1'b1;
         order_big_ff    <= 1'b0;
         count_ff        <= '0;
         target_ff       <= LEN_SETUP_HDR;
         known_ff        <= 1'b0;
         flush_ff        <= 1'b0;
         forced_ff       <= 1'b0;
      end else if (fire) begin
         expect_setup_ff <= expect_setup_in;
         order_big_ff    <= order_big_in;
         count_ff        <= count_in;
         target_ff       <= target_in;
         known_ff        <= known_in;
         flush_ff        <= flush_in;
         forced_ff       <= forced_in;
      end
   end

   // header capture, written before any read of the same byte
   always_ff @(posedge clock) begin
      if (fire && count_ff < LEN_HDR_BYTES) begin
         hdr_ff[count_ff[3:0]] <= cur;
      end
   end

   assign res_bus.out_byte         = cur;
   assign res_bus.first_of_message = first;
   assign res_bus.last_of_message  = done;
   assign res_bus.setup_message    = expect_setup_ff;
   assign res_bus.big_endian       = order_big_in;
   assign res_bus.message_length   = msg_len;
   assign res_bus.bytes_remaining  = remain;
   assign res_bus.length_forced    = forced_now;
   assign res_bus.flushed_setup    = flush_now;

endmodule

`default_nettype wire

@@ rtl/xrf_output_reg.sv @@
`default_nettype none

// Result register: holds a framed beat while the receiver stalls
module xrf_output_reg #(
   parameter int LENGTH_BITS = xrf_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   xrf_rsp_if.sink    res_bus,
   xrf_rsp_if.source  rsp_bus
);

   logic                   valid_ff;
   logic [7:0]             out_byte_ff;
   logic                   first_ff;
   logic                   last_ff;
   logic                   setup_ff;
   logic                   big_endian_ff;
   logic [LENGTH_BITS-1:0] length_ff;
   logic [LENGTH_BITS-1:0] remain_ff;
   logic                   forced_ff;
   logic                   flushed_ff;
   logic                   load;

   assign res_bus.ready = !valid_ff || rsp_bus.ready;
   assign load          = res_bus.valid && res_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_bus.ready) begin
         valid_ff <= res_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff   <= res_bus.out_byte;
         first_ff      <= res_bus.first_of_message;
         last_ff       <= res_bus.last_of_message;
         setup_ff      <= res_bus.setup_message;
         big_endian_ff <= res_bus.big_endian;
         length_ff     <= res_bus.message_length;
         remain_ff     <= res_bus.bytes_remaining;
         forced_ff     <= res_bus.length_forced;
         flushed_ff    <= res_bus.flushed_setup;
      end
   end

   assign rsp_bus.valid            = valid_ff;
   assign rsp_bus.out_byte         = out_byte_ff;
   assign rsp_bus.first_of_message = first_ff;
   assign rsp_bus.last_of_message  = last_ff;
   assign rsp_bus.setup_message    = setup_ff;
   assign rsp_bus.big_endian       = big_endian_ff;
   assign rsp_bus.message_length   = length_ff;
   assign rsp_bus.bytes_remaining  = remain_ff;
   assign rsp_bus.length_forced    = forced_ff;
   assign rsp_bus.flushed_setup    = flushed_ff;

endmodule

`default_nettype wire

@@ rtl/x11_request_framer.sv @@
// Frames an X11 client byte stream, one byte per beat.
// req_bus carries the stream (in_byte, burst_last); rsp_bus returns every
// byte unchanged with its framing: first/last of message, setup flag, byte
// order, message length, bytes still to come, forced and flushed flags.
// The first message is the connection setup, then requests follow, with
// BIG-REQUESTS lengths when the 16-bit length field is zero.
// csr_we/csr_index/csr_wdata write setup_limit (index 0) and
// big_request_limit (index 1); other indexes are ignored. Write only when idle.
// A beat accepted on req_bus passes an input register, then the length
// decode and the result register, before it is presented on rsp_bus.
// Throughput: one beat per cycle while rsp_bus.ready stays high; the
// framing state update sits between those two registers.
// Reset (synchronous): empties both registers, restores the limits to 4096
// and 104857600 and expects a fresh connection setup.
// Receiver stall: the result register holds its beat; a beat still enters
// while the input register is free, then req_bus.ready drops.
`default_nettype none

module x11_request_framer #(
   parameter int LENGTH_BITS = xrf_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [xrf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [xrf_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   xrf_req_if.sink                                  req_bus,
   xrf_rsp_if.source                                rsp_bus
);

   xrf_req_if                                 item_bus ();
   xrf_rsp_if #(.LENGTH_BITS(LENGTH_BITS))    res_bus ();

   // input register
   xrf_input_reg u_input_reg (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .item_bus (item_bus)
   );

   // framing state and decode
   xrf_frame_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_frame_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item_bus  (item_bus),
      .res_bus   (res_bus)
   );

   // result register
   xrf_output_reg #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_output_reg (
      .clock   (clock),
      .reset   (reset),
      .res_bus (res_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

@@ rtl/xrf_checker.sv @@
`default_nettype none

// Port-level checks on the framer
module xrf_checker #(
   parameter int LENGTH_BITS = xrf_pkg::LENGTH_BITS_DEFAULT
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [7:0]             rsp_out_byte,
   input wire logic                   rsp_first_of_message,
   input wire logic                   rsp_last_of_message,
   input wire logic                   rsp_setup_message,
   input wire logic [LENGTH_BITS-1:0] rsp_bytes_remaining
);

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] inflight_ff;
   logic       expect_first_ff;
   logic       setup_phase_ff;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // beats taken but not yet returned, and message boundary tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff     <= '0;
         expect_first_ff <= 1'b1;
         setup_phase_ff  <= 1'b1;
      end else begin
         inflight_ff <= inflight_ff + {1'b0, req_beat} - {1'b0, rsp_beat};
         if (rsp_beat) begin
            expect_first_ff <= rsp_last_of_message;
            if (rsp_last_of_message) begin
               setup_phase_ff <= 1'b0;
            end
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_bytes_remaining))
      else $error("result beat changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> inflight_ff != 2'd0)
      else $error("result beat without an accepted byte");

   a_first_follows_last: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> rsp_first_of_message == expect_first_ff)
      else $error("message start does not follow message end");

   a_setup_once: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> rsp_setup_message == setup_phase_ff)
      else $error("setup flag outside the first message");

endmodule

bind x11_request_framer xrf_checker #(
   .LENGTH_BITS (LENGTH_BITS)
) u_xrf_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_bus.valid),
   .req_ready            (req_bus.ready),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_out_byte         (rsp_bus.out_byte),
   .rsp_first_of_message (rsp_bus.first_of_message),
   .rsp_last_of_message  (rsp_bus.last_of_message),
   .rsp_setup_message    (rsp_bus.setup_message),
   .rsp_bytes_remaining  (rsp_bus.bytes_remaining)
);

`default_nettype wire
